// ===== design/gjs_pkg.sv =====
// ----------------------------------------------------------------------------
// gjs_pkg
// Shared types and constants for the 4x4 Gauss-Jordan solver.
// ----------------------------------------------------------------------------
package gjs_pkg;

    localparam int SIZE = 4;                  // matrix order
    localparam int NCOL = SIZE + 1;           // coefficients plus right side
    localparam int IW   = $clog2(SIZE);       // row / unknown index bits
    localparam int CW   = $clog2(NCOL + 1);   // counters that reach SIZE and NCOL-1
    localparam int WORD = 32;

    typedef logic signed [WORD-1:0] t_word;
    typedef logic [NCOL-1:0][WORD-1:0] t_row;

    localparam t_word WORD_MAX = t_word'(32'h7fff_ffff);
    localparam t_word WORD_MIN = t_word'(32'h8000_0000);

    typedef struct packed {
        logic [IW-1:0] row_index;
        t_word         coef_0;
        t_word         coef_1;
        t_word         coef_2;
        t_word         coef_3;
        t_word         rhs;
        logic          last_row;
    } t_in_item;

    typedef struct packed {
        t_word         solution;
        logic [IW-1:0] sol_index;
        logic          singular;
        logic          last;
    } t_out_item;

endpackage

// ===== design/gauss_jordan_solver_4x4.sv =====
// ----------------------------------------------------------------------------
// gauss_jordan_solver_4x4
// Loads a 4x4 fixed-point system row by row, solves it in place by
// Gauss-Jordan elimination on one shared multiplier and one serial divider,
// then streams out the four solution values.
// ----------------------------------------------------------------------------
//  channel   valid        stall        payload      direction
//  input     i_in_valid   o_in_stall   i_in_data    one matrix row per beat
//  output    o_out_valid  i_out_stall  o_out_data   one unknown per beat
//
//  A row beat without last_row is stored in the row memory when it is accepted.
//  A last_row beat is also stored and starts the solve: per pivot a row read and
//  check, a restoring reciprocal, then each element through the shared
//  multiplier (five elements, four rows), 4 write-backs and 5 row selects; a zero
//  pivot only marks the system singular. Each solution beat is read, loaded and sent.
//  o_in_stall is high from the solve start until the last solution beat leaves.
//  i_rst_n is synchronous; the row store itself is not cleared.
// ----------------------------------------------------------------------------
module gauss_jordan_solver_4x4 #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gjs_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gjs_pkg::t_out_item  o_out_data
);
    import gjs_pkg::*;

    localparam int DIVW = 2 * FRAC_BITS + 1;          // quotient bits of 2^(2F) / p
    localparam int DCW  = $clog2(DIVW + 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_PRD   = 12'b0000_0000_0010,
        S_PCHK  = 12'b0000_0000_0100,
        S_DIV   = 12'b0000_0000_1000,
        S_REC   = 12'b0000_0001_0000,
        S_MUL   = 12'b0000_0010_0000,
        S_ACC   = 12'b0000_0100_0000,
        S_WB    = 12'b0000_1000_0000,
        S_NEXTJ = 12'b0001_0000_0000,
        S_ORD   = 12'b0010_0000_0000,
        S_OLD   = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    t_row            r_mem [SIZE];
    t_row            r_rd;
    t_row            r_piv;
    t_row            r_wr;
    t_state          r_state;
    logic [IW-1:0]   r_i;
    logic [CW-1:0]   r_j;
    logic [CW-1:0]   r_k;
    logic            r_scl;
    logic            r_sing;
    logic            r_neg;
    logic [WORD-1:0] r_dvs;
    logic [WORD:0]   r_rem;
    logic [DIVW-1:0] r_q;
    logic [DCW-1:0]  r_dcnt;
    t_word           r_recip;
    logic signed [2*WORD-1:0] r_prod;
    logic            r_oval;
    t_out_item       r_out;

    // memory port controls
    logic            w_we;
    logic [IW-1:0]   w_waddr;
    t_row            w_wdata;
    logic            w_re;
    logic [IW-1:0]   w_raddr;

    logic            w_in_acc;
    t_row            w_in_row;
    t_word           w_pivot;
    t_word           w_mul_a;
    t_word           w_mul_b;
    logic [WORD:0]   w_rem_sh;
    logic            w_rem_ge;
    logic [63:0]     w_q64;
    t_word           n_recip;
    logic signed [2*WORD-1:0] w_shift;
    t_word           n_mul;
    logic signed [WORD:0] w_diff;
    t_word           n_sub;
    logic [IW-1:0]   w_wb_row;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    assign w_in_row = {i_in_data.rhs, i_in_data.coef_3, i_in_data.coef_2,
                       i_in_data.coef_1, i_in_data.coef_0};
    assign w_pivot  = t_word'(r_rd[CW'(r_i)]);
    assign w_wb_row = r_scl ? r_i : r_j[IW-1:0];

    // shared multiplier operands: scaling uses the reciprocal, elimination the ratio
    assign w_mul_a = r_scl ? t_word'(r_rd[r_k]) : w_pivot;
    assign w_mul_b = r_scl ? r_recip : t_word'(r_piv[r_k]);

    // restoring divider step; numerator 2^(2F) has only its top bit set
    assign w_rem_sh = {r_rem[WORD-1:0], (r_dcnt == '0)};
    assign w_rem_ge = (w_rem_sh >= {1'b0, r_dvs});
    assign w_q64    = 64'(r_q);

    always_comb begin
        if (r_neg) begin
            n_recip = (w_q64 > 64'h0000_0000_8000_0000) ? WORD_MIN
                                                        : t_word'(-w_q64[WORD-1:0]);
        end else begin
            n_recip = (w_q64 > 64'h0000_0000_7fff_ffff) ? WORD_MAX
                                                        : t_word'(w_q64[WORD-1:0]);
        end
    end

    // arithmetic shift floors, matching round toward minus infinity
    assign w_shift = r_prod >>> FRAC_BITS;
    always_comb begin
        if (w_shift > 64'(WORD_MAX))       n_mul = WORD_MAX;
        else if (w_shift < 64'(WORD_MIN))  n_mul = WORD_MIN;
        else                               n_mul = t_word'(w_shift[WORD-1:0]);
    end

    assign w_diff = (WORD+1)'($signed(r_rd[r_k])) - (WORD+1)'(n_mul);
    always_comb begin
        if (w_diff > (WORD+1)'(WORD_MAX))      n_sub = WORD_MAX;
        else if (w_diff < (WORD+1)'(WORD_MIN)) n_sub = WORD_MIN;
        else                                   n_sub = t_word'(w_diff[WORD-1:0]);
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_in_data.row_index;
        w_wdata = w_in_row;
        w_re    = 1'b0;
        w_raddr = r_i;
        if (w_in_acc && (32'(i_in_data.row_index) < SIZE)) begin
            w_we = 1'b1;
        end else if (r_state == S_WB) begin
            w_we    = 1'b1;
            w_waddr = w_wb_row;
            w_wdata = r_wr;
        end
        unique case (r_state)
            S_PRD:   w_re = 1'b1;
            S_NEXTJ: begin
                w_re    = (r_j != CW'(SIZE)) && (r_j != CW'(r_i));
                w_raddr = r_j[IW-1:0];
            end
            S_ORD:   begin
                w_re    = 1'b1;
                w_raddr = r_k[IW-1:0];
            end
            default: w_re = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sing  <= 1'b0;
            r_oval  <= 1'b0;
            r_scl   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_dcnt  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_in_data.last_row) begin
                        r_sing  <= 1'b0;
                        r_i     <= '0;
                        r_state <= S_PRD;
                    end
                end
                S_PRD: r_state <= S_PCHK;
                S_PCHK: begin
                    if (w_pivot == '0) begin
                        r_sing <= 1'b1;
                        if (r_i == IW'(SIZE - 1)) begin
                            r_k     <= '0;
                            r_state <= S_ORD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_PRD;
                        end
                    end else begin
                        r_neg   <= w_pivot[WORD-1];
                        r_dvs   <= w_pivot[WORD-1] ? WORD'(-w_pivot) : WORD'(w_pivot);
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_rem_ge ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
                    r_q   <= {r_q[DIVW-2:0], w_rem_ge};
                    if (r_dcnt == DCW'(DIVW - 1)) begin
                        r_state <= S_REC;
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_REC: begin
                    r_recip <= n_recip;
                    r_scl   <= 1'b1;
                    r_k     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_wr[r_k] <= r_scl ? n_mul : n_sub;
                    if (r_k == CW'(NCOL - 1)) begin
                        r_state <= S_WB;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_WB: begin
                    if (r_scl) begin
                        r_piv <= r_wr;
                        r_scl <= 1'b0;
                        r_j   <= '0;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                    r_state <= S_NEXTJ;
                end
                S_NEXTJ: begin
                    r_k <= '0;
                    if (r_j == CW'(SIZE)) begin
                        if (r_i == IW'(SIZE - 1)) begin
                            r_state <= S_ORD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_PRD;
                        end
                    end else if (r_j == CW'(r_i)) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_state <= S_MUL;       // row j lands in r_rd this edge
                    end
                end
                S_ORD: r_state <= S_OLD;
                S_OLD: begin
                    r_out.solution  <= t_word'(r_rd[NCOL-1]);
                    r_out.sol_index <= r_k[IW-1:0];
                    r_out.singular  <= r_sing;
                    r_out.last      <= (r_k == CW'(SIZE - 1));
                    r_oval          <= 1'b1;
                    r_state         <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_oval <= 1'b0;
                        if (r_k == CW'(SIZE - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_input_during_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a solution beat is pending");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> (o_out_data.sol_index == IW'(SIZE - 1)))
        else $error("last flag on wrong unknown");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dcnt < DCW'(DIVW)))
        else $error("divider count overran");

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PCHK) |-> ($past(r_state) == S_PRD))
        else $error("pivot checked without a fresh row read");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Random and directed test of the 4x4 Gauss-Jordan solver. A clocked driver
// sends row beats from a queue. Each accepted row also updates a fixed-point
// elimination predictor in the bench. A clocked monitor compares every
// solution beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;
    import gjs_pkg::*;

    localparam int  FRAC       = 16;
    localparam int  CYCLE_CAP  = 400000;
    localparam int  DRAIN      = 2000;
    localparam int  N_RANDOM   = 85;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    gauss_jordan_solver_4x4 #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_item  row_queue[$];
    t_out_item solution_queue[$];
    int        err_count = 0;
    int        cycle_count = 0;
    bit        stim_done = 1'b0;

    // bench copy of the stored system
    longint    mat_copy[SIZE][SIZE];
    longint    rhs_copy[SIZE];

    function automatic longint sat_word(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // product floored by FRAC bits
    function automatic longint q_mul(longint a, longint b);
        return sat_word((a * b) >>> FRAC);
    endfunction

    function automatic longint q_recip(longint p);
        longint num;
        num = longint'(1) << (2 * FRAC);
        return sat_word(num / p);
    endfunction

    task automatic eliminate_and_expect();
        longint    r;
        longint    ratio;
        bit        sing;
        t_out_item s;
        sing = 1'b0;
        for (int i = 0; i < SIZE; i++) begin
            if (mat_copy[i][i] == 0) begin
                sing = 1'b1;
                continue;
            end
            r = q_recip(mat_copy[i][i]);
            for (int k = 0; k < SIZE; k++) mat_copy[i][k] = q_mul(mat_copy[i][k], r);
            rhs_copy[i] = q_mul(rhs_copy[i], r);
            for (int j = 0; j < SIZE; j++) begin
                if (j == i) continue;
                ratio = mat_copy[j][i];
                for (int k = 0; k < SIZE; k++)
                    mat_copy[j][k] = sat_word(mat_copy[j][k] - q_mul(ratio, mat_copy[i][k]));
                rhs_copy[j] = sat_word(rhs_copy[j] - q_mul(ratio, rhs_copy[i]));
            end
        end
        for (int k = 0; k < SIZE; k++) begin
            s.solution  = t_word'(rhs_copy[k]);
            s.sol_index = k[IW-1:0];
            s.singular  = sing;
            s.last      = (k == SIZE - 1);
            solution_queue.push_back(s);
        end
    endtask

    task automatic store_row(t_in_item it);
        mat_copy[it.row_index][0] = longint'(it.coef_0);
        mat_copy[it.row_index][1] = longint'(it.coef_1);
        mat_copy[it.row_index][2] = longint'(it.coef_2);
        mat_copy[it.row_index][3] = longint'(it.coef_3);
        rhs_copy[it.row_index]    = longint'(it.rhs);
        if (it.last_row) eliminate_and_expect();
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 11) == 0) return $urandom_range(12, 60);
        return $urandom_range(0, 2);
    endfunction

    // ---------------- driver
    int gap_left = 0;
    bit quiet_in = 1'b0;
    always @(posedge i_clk) begin
        logic     next_valid;
        t_in_item next_data;
        next_valid = i_in_valid;
        next_data  = i_in_data;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                store_row(i_in_data);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0 && !quiet_in) begin
                    gap_left--;
                end else if (row_queue.size() > 0) begin
                    next_valid = 1'b1;
                    next_data  = row_queue.pop_front();
                    gap_left   = pick_gap();
                    if ($urandom_range(0, 29) == 0) quiet_in = ~quiet_in;
                end
            end
        end
        i_in_valid <= next_valid;
        i_in_data  <= next_data;
    end

    // ---------------- output stall and monitor
    int stall_left = 0;
    int free_left = 0;
    always @(posedge i_clk) begin
        t_out_item want;
        cycle_count++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (solution_queue.size() == 0) begin
                $error("unexpected solution beat index %0d", o_out_data.sol_index);
                err_count++;
            end else begin
                want = solution_queue.pop_front();
                if (o_out_data.solution !== want.solution) begin
                    $error("solution: expected %0d, got %0d", want.solution,
                           o_out_data.solution);
                    err_count++;
                end
                if (o_out_data.sol_index !== want.sol_index) begin
                    $error("sol_index: expected %0d, got %0d", want.sol_index,
                           o_out_data.sol_index);
                    err_count++;
                end
                if (o_out_data.singular !== want.singular) begin
                    $error("singular: expected %0d, got %0d", want.singular,
                           o_out_data.singular);
                    err_count++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_out_data.last);
                    err_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= 1'b0;
            free_left  = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 4);
            stall_left = pick_gap();
        end
        if (cycle_count > CYCLE_CAP) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ---------------- stimulus
    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3, 4:    return t_word'($urandom);
            default: return t_word'(($signed($urandom_range(0, 16)) - 8) * 65536
                                    + $signed($urandom_range(0, 65535)));
        endcase
    endfunction

    function automatic t_in_item make_row(int r, t_word c0, t_word c1, t_word c2,
                                          t_word c3, t_word b, bit fin);
        t_in_item it;
        it.row_index = r[IW-1:0];
        it.coef_0 = c0; it.coef_1 = c1; it.coef_2 = c2; it.coef_3 = c3;
        it.rhs = b;
        it.last_row = fin;
        return it;
    endfunction

    // diagonally heavy system (random words when wild), rows in random order, last one flagged
    task automatic push_system(bit wild);
        int       order[SIZE];
        int       t, a;
        t_word    c[SIZE];
        for (int k = 0; k < SIZE; k++) order[k] = k;
        for (int k = SIZE - 1; k > 0; k--) begin
            a = $urandom_range(0, k);
            t = order[k]; order[k] = order[a]; order[a] = t;
        end
        for (int k = 0; k < SIZE; k++) begin
            for (int m = 0; m < SIZE; m++)
                c[m] = wild ? rand_word()
                            : t_word'($signed($urandom_range(0, 131071)) - 65536);
            if (!wild) c[order[k]] = t_word'($urandom_range(4, 12) * 65536
                                            + $urandom_range(0, 65535));
            row_queue.push_back(make_row(order[k], c[0], c[1], c[2], c[3],
                                         wild ? rand_word() : t_word'($urandom),
                                         k == SIZE - 1));
        end
    endtask

    localparam t_word ONE = t_word'(32'h0001_0000);
    localparam t_word TWO = t_word'(32'h0002_0000);

    initial begin
        // identity with extreme right sides
        row_queue.push_back(make_row(0, ONE, 0, 0, 0, WORD_MAX, 0));
        row_queue.push_back(make_row(1, 0, ONE, 0, 0, WORD_MIN, 0));
        row_queue.push_back(make_row(2, 0, 0, ONE, 0, 0, 0));
        row_queue.push_back(make_row(3, 0, 0, 0, ONE, t_word'(-1), 1));
        // repeated solve on the reduced system
        row_queue.push_back(make_row(3, 0, 0, 0, TWO, TWO, 1));
        // zero pivot in column one
        row_queue.push_back(make_row(1, ONE, 0, ONE, 0, ONE, 1));
        // saturating coefficients, pivot of -1 lsb and of max
        row_queue.push_back(make_row(0, t_word'(-1), WORD_MAX, WORD_MIN, 1, WORD_MAX, 0));
        row_queue.push_back(make_row(1, WORD_MIN, WORD_MAX, 0, t_word'(-1), WORD_MIN, 0));
        row_queue.push_back(make_row(2, 1, 0, WORD_MIN, WORD_MAX, 1, 0));
        row_queue.push_back(make_row(3, WORD_MAX, WORD_MIN, t_word'(-1), WORD_MAX,
                                     t_word'(32'h5555_aaaa), 1));
        // all zero system: every pivot zero
        for (int r = 0; r < SIZE; r++)
            row_queue.push_back(make_row(r, 0, 0, 0, 0, t_word'(32'haaaa_5555), r == 3));
        push_system(1'b0);
        push_system(1'b1);
        while (row_queue.size() < 25 + N_RANDOM) begin
            if ($urandom_range(0, 4) == 0)
                row_queue.push_back(make_row($urandom_range(0, 3), rand_word(),
                                             rand_word(), rand_word(), rand_word(),
                                             rand_word(), $urandom_range(0, 1)));
            else
                push_system($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (row_queue.size() == 0 && !i_in_valid && solution_queue.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (err_count == 0 && solution_queue.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
